// ===== rtl/mnc_pkg.sv =====
// Shared types, codes and widths of the Mahalanobis nearest-center classifier.
package mnc_pkg;

    // default sizes handed to the top-level parameters
    localparam int DEF_MAX_CENTERS   = 8;
    localparam int DEF_MAX_DIMS      = 4;
    localparam int DEF_COV_FRAC_BITS = 12;

    // item kinds
    localparam logic [1:0] KIND_CENTER = 2'd0;
    localparam logic [1:0] KIND_COV    = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CENTERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_DIMS    = 1'b1;
    localparam logic [3:0] ACTIVE_CENTERS_RST = 4'd8;
    localparam logic [2:0] ACTIVE_DIMS_RST    = 3'd4;

    // payload widths
    localparam int DATA_W    = 16;
    localparam int NUM_COMPS = 4;
    localparam int IDX_W     = 3;
    localparam int CNT_C_W   = 4;   // holds active_centers
    localparam int CNT_D_W   = 3;   // holds active_dims
    localparam int DIST_W    = 42;

    // datapath widths: at most seven dims are ever in use
    localparam int DIFF_W = DATA_W + 1;
    localparam int LO_W   = 20;
    localparam int B_W    = LO_W + 1;
    localparam int PROD_W = DIFF_W + B_W;
    localparam int ACC_W  = 36;
    localparam int HI_W   = ACC_W - LO_W;
    localparam int Q_W    = 56;

    // operations issued to the shared multiply-accumulate
    localparam logic [2:0] OP_NONE = 3'd0;
    localparam logic [2:0] OP_DI   = 3'd1;  // latch d_i for the current row
    localparam logic [2:0] OP_SD   = 3'd2;  // S[i][j] * d_j into row accumulator
    localparam logic [2:0] OP_LO   = 3'd3;  // d_i * low part of row sum into form
    localparam logic [2:0] OP_HI   = 3'd4;  // d_i * high part of row sum into form

    typedef logic [NUM_COMPS-1:0][DATA_W-1:0] comps_t;

    typedef struct packed {
        logic [2:0]         op;
        logic               first;
        logic               last_row;
        logic               last_center;
        logic [CNT_C_W-1:0] center;
    } mac_tag_t;

    typedef struct packed {
        logic [CNT_C_W-1:0] center;
        logic [CNT_D_W-1:0] row;
        logic [CNT_D_W-1:0] col;
    } rd_addr_t;

    typedef struct packed {
        logic               found;
        logic [CNT_C_W-1:0] center;
        logic [Q_W-1:0]     form;
    } best_t;

endpackage

// ===== rtl/mnc_in_if.sv =====
// Input channel: one load or classify transaction per handshake.
interface mnc_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          kind;
    logic [mnc_pkg::IDX_W-1:0]           index;
    logic signed [mnc_pkg::DATA_W-1:0]   comp0;
    logic signed [mnc_pkg::DATA_W-1:0]   comp1;
    logic signed [mnc_pkg::DATA_W-1:0]   comp2;
    logic signed [mnc_pkg::DATA_W-1:0]   comp3;

    modport source (output valid, kind, index, comp0, comp1, comp2, comp3, input ready);
    modport sink   (input valid, kind, index, comp0, comp1, comp2, comp3, output ready);
endinterface

// ===== rtl/mnc_out_if.sv =====
// Result channel: nearest center and its squared distance.
interface mnc_out_if;
    logic                          valid;
    logic                          ready;
    logic [mnc_pkg::IDX_W-1:0]     nearest_center;
    logic [mnc_pkg::DIST_W-1:0]    squared_distance;
    logic                          found;

    modport source (output valid, nearest_center, squared_distance, found, input ready);
    modport sink   (input valid, nearest_center, squared_distance, found, output ready);
endinterface

// ===== rtl/mnc_store.sv =====
// Center and inverse covariance memories plus the sample register.
module mnc_store #(
    parameter int MAX_CENTERS = mnc_pkg::DEF_MAX_CENTERS,
    parameter int MAX_DIMS    = mnc_pkg::DEF_MAX_DIMS
) (
    input  logic                               clk,
    input  logic                               cen_we,
    input  logic                               cov_we,
    input  logic                               smp_we,
    input  logic [mnc_pkg::IDX_W-1:0]          wr_index,
    input  mnc_pkg::comps_t                    wr_comps,
    input  mnc_pkg::rd_addr_t                  rd_addr,
    output logic [mnc_pkg::DATA_W-1:0]         cen_word,
    output logic [mnc_pkg::DATA_W-1:0]         cov_word,
    output logic [mnc_pkg::DATA_W-1:0]         x_word
);

    localparam int CAW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int DAW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    typedef logic [MAX_DIMS-1:0][mnc_pkg::DATA_W-1:0] row_t;

    row_t center_mem [MAX_CENTERS];
    row_t cov_mem    [MAX_DIMS];
    row_t x_reg;

    row_t wr_row;
    row_t cen_row_reg;
    row_t cov_row_reg;
    logic [DAW-1:0] col_reg;
    logic [mnc_pkg::DATA_W-1:0] x_word_reg;

    logic [CAW+mnc_pkg::IDX_W-1:0]   wr_cen_ext;
    logic [DAW+mnc_pkg::IDX_W-1:0]   wr_cov_ext;
    logic [CAW+mnc_pkg::CNT_C_W-1:0] rd_cen_ext;
    logic [DAW+mnc_pkg::CNT_D_W-1:0] rd_row_ext;
    logic [DAW+mnc_pkg::CNT_D_W-1:0] rd_col_ext;

    // components past comp3 load as zero
    genvar k;
    generate
        for (k = 0; k < MAX_DIMS; k++)
        begin : g_row
            if (k < mnc_pkg::NUM_COMPS)
            begin : g_comp
                assign wr_row[k] = wr_comps[k];
            end
            else
            begin : g_zero
                assign wr_row[k] = '0;
            end
        end
    endgenerate

    assign wr_cen_ext = {{CAW{1'b0}}, wr_index};
    assign wr_cov_ext = {{DAW{1'b0}}, wr_index};
    assign rd_cen_ext = {{CAW{1'b0}}, rd_addr.center};
    assign rd_row_ext = {{DAW{1'b0}}, rd_addr.row};
    assign rd_col_ext = {{DAW{1'b0}}, rd_addr.col};

    always_ff @(posedge clk)
    begin
        if (cen_we)
        begin
            center_mem[wr_cen_ext[CAW-1:0]] <= wr_row;
        end
        if (cov_we)
        begin
            cov_mem[wr_cov_ext[DAW-1:0]] <= wr_row;
        end
        if (smp_we)
        begin
            x_reg <= wr_row;
        end
        cen_row_reg <= center_mem[rd_cen_ext[CAW-1:0]];
        cov_row_reg <= cov_mem[rd_row_ext[DAW-1:0]];
        x_word_reg  <= x_reg[rd_col_ext[DAW-1:0]];
        col_reg     <= rd_col_ext[DAW-1:0];
    end

    assign cen_word = cen_row_reg[col_reg];
    assign cov_word = cov_row_reg[col_reg];
    assign x_word   = x_word_reg;

endmodule

// ===== rtl/mnc_mac.sv =====
// Shared multiply-accumulate pipeline: difference, multiply, accumulate, compare.
module mnc_mac (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  mnc_pkg::mac_tag_t             tag,
    input  logic [mnc_pkg::DATA_W-1:0]    cen_word,
    input  logic [mnc_pkg::DATA_W-1:0]    cov_word,
    input  logic [mnc_pkg::DATA_W-1:0]    x_word,
    output logic                          done,
    output mnc_pkg::best_t                best
);

    mnc_pkg::mac_tag_t tag1_reg;
    mnc_pkg::mac_tag_t tag2_reg;
    mnc_pkg::mac_tag_t tag3_reg;

    logic signed [mnc_pkg::DIFF_W-1:0] diff;
    logic signed [mnc_pkg::DIFF_W-1:0] di_reg;
    logic signed [mnc_pkg::DIFF_W-1:0] a_reg;
    logic signed [mnc_pkg::B_W-1:0]    b_reg;
    logic signed [mnc_pkg::PROD_W-1:0] prod_reg;
    logic signed [mnc_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mnc_pkg::Q_W-1:0]    q_reg;
    logic signed [mnc_pkg::Q_W-1:0]    prod_q;
    logic signed [mnc_pkg::Q_W-1:0]    best_q;

    logic                              cmp_reg;
    logic                              cmp_last_reg;
    logic [mnc_pkg::CNT_C_W-1:0]       cmp_center_reg;
    logic                              done_reg;
    logic                              found_reg;
    logic [mnc_pkg::CNT_C_W-1:0]       best_c_reg;
    logic [mnc_pkg::Q_W-1:0]           best_q_reg;
    logic                              better;

    assign diff   = $signed({x_word[mnc_pkg::DATA_W-1], x_word})
                  - $signed({cen_word[mnc_pkg::DATA_W-1], cen_word});
    assign prod_q = mnc_pkg::Q_W'(prod_reg);
    assign best_q = $signed(best_q_reg);
    assign better = (q_reg >= 0) && (!found_reg || (q_reg < best_q));

    // tags: one per pipeline stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg     <= '0;
            tag2_reg     <= '0;
            tag3_reg     <= '0;
            cmp_reg      <= 1'b0;
            cmp_last_reg <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            tag1_reg     <= tag;
            tag2_reg     <= tag1_reg;
            tag3_reg     <= tag2_reg;
            cmp_reg      <= (tag3_reg.op == mnc_pkg::OP_HI) && tag3_reg.last_row;
            cmp_last_reg <= tag3_reg.last_center;
            done_reg     <= cmp_reg && cmp_last_reg;
            if (start)
            begin
                found_reg <= 1'b0;
            end
            else if (cmp_reg && better)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // operand stage
    always_ff @(posedge clk)
    begin
        unique case (tag1_reg.op)
            mnc_pkg::OP_DI:
            begin
                di_reg <= diff;
            end
            mnc_pkg::OP_SD:
            begin
                a_reg <= diff;
                b_reg <= mnc_pkg::B_W'($signed(cov_word));
            end
            mnc_pkg::OP_LO:
            begin
                a_reg <= di_reg;
                b_reg <= $signed({1'b0, acc_reg[mnc_pkg::LO_W-1:0]});
            end
            mnc_pkg::OP_HI:
            begin
                a_reg <= di_reg;
                b_reg <= mnc_pkg::B_W'($signed(acc_reg[mnc_pkg::ACC_W-1:mnc_pkg::LO_W]));
            end
            default:
            begin
            end
        endcase
    end

    // multiply stage
    always_ff @(posedge clk)
    begin
        prod_reg <= a_reg * b_reg;
    end

    // accumulate stage; the row sum reaches the form as two partial products
    always_ff @(posedge clk)
    begin
        unique case (tag3_reg.op)
            mnc_pkg::OP_SD:
            begin
                if (tag3_reg.first)
                begin
                    acc_reg <= mnc_pkg::ACC_W'(prod_reg);
                end
                else
                begin
                    acc_reg <= acc_reg + mnc_pkg::ACC_W'(prod_reg);
                end
            end
            mnc_pkg::OP_LO:
            begin
                if (tag3_reg.first)
                begin
                    q_reg <= prod_q;
                end
                else
                begin
                    q_reg <= q_reg + prod_q;
                end
            end
            mnc_pkg::OP_HI:
            begin
                q_reg <= q_reg + (prod_q <<< mnc_pkg::LO_W);
            end
            default:
            begin
            end
        endcase
    end

    // compare stage: strict less keeps the lowest index on ties
    always_ff @(posedge clk)
    begin
        if (cmp_reg && better)
        begin
            best_q_reg <= q_reg;
            best_c_reg <= cmp_center_reg;
        end
        cmp_center_reg <= tag3_reg.center;
    end

    assign done        = done_reg;
    assign best.found  = found_reg;
    assign best.center = best_c_reg;
    assign best.form   = best_q_reg;

endmodule

// ===== rtl/mnc_seq.sv =====
// Sequencer that walks centers, rows and columns through the shared MAC.
module mnc_seq (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [mnc_pkg::CNT_C_W-1:0]      num_centers,
    input  logic [mnc_pkg::CNT_D_W-1:0]      num_dims,
    input  logic                             done,
    input  logic                             take,
    output logic                             idle,
    output logic                             hold,
    output mnc_pkg::mac_tag_t                tag,
    output mnc_pkg::rd_addr_t                rd_addr
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DI    = 4'd1;
    localparam logic [3:0] ST_SD    = 4'd2;
    localparam logic [3:0] ST_GAP1  = 4'd3;
    localparam logic [3:0] ST_GAP2  = 4'd4;
    localparam logic [3:0] ST_LO    = 4'd5;
    localparam logic [3:0] ST_HI    = 4'd6;
    localparam logic [3:0] ST_DRAIN = 4'd7;
    localparam logic [3:0] ST_HOLD  = 4'd8;

    logic [3:0]                  state_reg, state_next;
    logic [mnc_pkg::CNT_C_W-1:0] c_reg, c_next;
    logic [mnc_pkg::CNT_D_W-1:0] i_reg, i_next;
    logic [mnc_pkg::CNT_D_W-1:0] j_reg, j_next;
    logic [mnc_pkg::CNT_C_W-1:0] c_last;
    logic [mnc_pkg::CNT_D_W-1:0] d_last;

    assign c_last = num_centers - mnc_pkg::CNT_C_W'(1);
    assign d_last = num_dims - mnc_pkg::CNT_D_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            c_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            c_reg     <= c_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        c_next              = c_reg;
        i_next              = i_reg;
        j_next              = j_reg;
        tag                 = '0;
        tag.op              = mnc_pkg::OP_NONE;
        tag.center          = c_reg;
        rd_addr.center      = c_reg;
        rd_addr.row         = i_reg;
        rd_addr.col         = j_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    c_next = '0;
                    i_next = '0;
                    j_next = '0;
                    if ((num_centers == '0) || (num_dims == '0))
                    begin
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        state_next = ST_DI;
                    end
                end
            end
            ST_DI:
            begin
                tag.op      = mnc_pkg::OP_DI;
                rd_addr.col = i_reg;
                j_next      = '0;
                state_next  = ST_SD;
            end
            ST_SD:
            begin
                tag.op    = mnc_pkg::OP_SD;
                tag.first = (j_reg == '0);
                if (j_reg == d_last)
                begin
                    state_next = ST_GAP1;
                end
                else
                begin
                    j_next = j_reg + mnc_pkg::CNT_D_W'(1);
                end
            end
            // row sum still in flight through multiply and accumulate
            ST_GAP1:
            begin
                state_next = ST_GAP2;
            end
            ST_GAP2:
            begin
                state_next = ST_LO;
            end
            ST_LO:
            begin
                tag.op     = mnc_pkg::OP_LO;
                tag.first  = (i_reg == '0);
                state_next = ST_HI;
            end
            ST_HI:
            begin
                tag.op          = mnc_pkg::OP_HI;
                tag.last_row    = (i_reg == d_last);
                tag.last_center = (c_reg == c_last);
                if (i_reg != d_last)
                begin
                    i_next     = i_reg + mnc_pkg::CNT_D_W'(1);
                    state_next = ST_DI;
                end
                else if (c_reg != c_last)
                begin
                    c_next     = c_reg + mnc_pkg::CNT_C_W'(1);
                    i_next     = '0;
                    state_next = ST_DI;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (take)
                begin
                    c_next     = '0;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == ST_IDLE);
    assign hold = (state_reg == ST_HOLD);

endmodule

// ===== rtl/mahalanobis_nearest_center.sv =====
// Top level of the Mahalanobis nearest-center classifier.
// Center and covariance loads are written on accept and leave the block ready for more items.
// A classify transaction keeps the block busy from accept until its result is taken by the
// output register; its work is set by the single shared 17x21 multiplier and by gap states
// in each row while its sum settles.
// Reset clears control and config (8 centers, 4 dims); both stores stay unwritten.
module mahalanobis_nearest_center #(
    parameter int MAX_CENTERS   = mnc_pkg::DEF_MAX_CENTERS,
    parameter int MAX_DIMS      = mnc_pkg::DEF_MAX_DIMS,
    parameter int COV_FRAC_BITS = mnc_pkg::DEF_COV_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    mnc_in_if.sink                               item,
    mnc_out_if.source                            result,
    input  logic                                 cfg_we,
    input  logic [mnc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mnc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [mnc_pkg::CNT_C_W-1:0] active_centers_reg;
    logic [mnc_pkg::CNT_D_W-1:0] active_dims_reg;
    logic [mnc_pkg::CNT_C_W-1:0] num_centers;
    logic [mnc_pkg::CNT_D_W-1:0] num_dims;

    logic accept, start, cen_we, cov_we, smp_we;
    logic idle, hold, take, done;
    logic zero_dims_reg;

    mnc_pkg::comps_t   comps;
    mnc_pkg::mac_tag_t tag;
    mnc_pkg::rd_addr_t rd_addr;
    mnc_pkg::best_t    best;

    logic [mnc_pkg::DATA_W-1:0] cen_word, cov_word, x_word;
    logic [mnc_pkg::Q_W-1:0]    q_shift;
    logic [mnc_pkg::DIST_W-1:0] sat_dist;

    logic                       out_valid_reg;
    logic [mnc_pkg::IDX_W-1:0]  out_center_reg;
    logic [mnc_pkg::DIST_W-1:0] out_dist_reg;
    logic                       out_found_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_centers_reg <= mnc_pkg::ACTIVE_CENTERS_RST;
            active_dims_reg    <= mnc_pkg::ACTIVE_DIMS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mnc_pkg::REG_ACTIVE_CENTERS:
                begin
                    active_centers_reg <= cfg_data[mnc_pkg::CNT_C_W-1:0];
                end
                mnc_pkg::REG_ACTIVE_DIMS:
                begin
                    active_dims_reg <= cfg_data[mnc_pkg::CNT_D_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign num_centers = (32'(active_centers_reg) > MAX_CENTERS)
                       ? mnc_pkg::CNT_C_W'(MAX_CENTERS) : active_centers_reg;
    assign num_dims    = (32'(active_dims_reg) > MAX_DIMS)
                       ? mnc_pkg::CNT_D_W'(MAX_DIMS) : active_dims_reg;

    // input transactions
    assign item.ready = idle;
    assign accept     = item.valid && idle;
    assign cen_we     = accept && (item.kind == mnc_pkg::KIND_CENTER)
                     && (32'(item.index) < MAX_CENTERS);
    assign cov_we     = accept && (item.kind == mnc_pkg::KIND_COV)
                     && (32'(item.index) < MAX_DIMS);
    assign smp_we     = accept && (item.kind == mnc_pkg::KIND_SAMPLE);
    assign start      = smp_we;

    assign comps[0] = item.comp0;
    assign comps[1] = item.comp1;
    assign comps[2] = item.comp2;
    assign comps[3] = item.comp3;

    // with no dims in use every form is zero and center 0 wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_dims_reg <= 1'b0;
        end
        else if (start)
        begin
            zero_dims_reg <= (num_dims == '0) && (num_centers != '0);
        end
    end

    mnc_store #(
        .MAX_CENTERS (MAX_CENTERS),
        .MAX_DIMS    (MAX_DIMS)
    ) u_store (
        .clk      (clk),
        .cen_we   (cen_we),
        .cov_we   (cov_we),
        .smp_we   (smp_we),
        .wr_index (item.index),
        .wr_comps (comps),
        .rd_addr  (rd_addr),
        .cen_word (cen_word),
        .cov_word (cov_word),
        .x_word   (x_word)
    );

    mnc_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .num_centers (num_centers),
        .num_dims    (num_dims),
        .done        (done),
        .take        (take),
        .idle        (idle),
        .hold        (hold),
        .tag         (tag),
        .rd_addr     (rd_addr)
    );

    mnc_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .tag      (tag),
        .cen_word (cen_word),
        .cov_word (cov_word),
        .x_word   (x_word),
        .done     (done),
        .best     (best)
    );

    // drop fraction bits, saturate to the result width
    assign q_shift  = best.form >> COV_FRAC_BITS;
    assign sat_dist = (|q_shift[mnc_pkg::Q_W-1:mnc_pkg::DIST_W])
                    ? {mnc_pkg::DIST_W{1'b1}} : q_shift[mnc_pkg::DIST_W-1:0];

    // output register
    assign take = hold && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (zero_dims_reg)
            begin
                out_center_reg <= '0;
                out_dist_reg   <= '0;
                out_found_reg  <= 1'b1;
            end
            else if (best.found)
            begin
                out_center_reg <= best.center[mnc_pkg::IDX_W-1:0];
                out_dist_reg   <= sat_dist;
                out_found_reg  <= 1'b1;
            end
            else
            begin
                out_center_reg <= '0;
                out_dist_reg   <= '0;
                out_found_reg  <= 1'b0;
            end
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.nearest_center   = out_center_reg;
    assign result.squared_distance = out_dist_reg;
    assign result.found            = out_found_reg;

endmodule
